// ===== sv/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// No dependencies; imported by every module of the block but tcw_ram.
`default_nettype none

package tcw_pkg;

    localparam int CHAR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int ROW_FLD_W  = 5;
    localparam int COL_FLD_W  = 7;
    localparam int COLOR_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE    = 8'd10;
    localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [CHAR_W-1:0] LAST_PRINTABLE  = 8'd127;

    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FORE_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR = 2'd1;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic scroll_step;
        logic load_out;
    } tcw_cmd_t;

    typedef struct packed {
        logic need_scroll;
        logic sweep_last;
        logic out_free;
    } tcw_status_t;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCROLL = 4'b0100,
        ST_PUSH   = 4'b1000
    } tcw_state_t;

endpackage

`default_nettype wire

// ===== sv/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/tcw_datapath.sv =====
// Datapath: screen RAM, cursor, color registers, sweep counter, result register.
// Depends on tcw_pkg and tcw_ram.
`default_nettype none

module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire tcw_pkg::tcw_cmd_t                     cmd,
    output tcw_pkg::tcw_status_t                       status,
    input  wire logic                                  in_kind,
    input  wire logic [tcw_pkg::CHAR_W-1:0]            in_char,
    input  wire logic [tcw_pkg::ROW_FLD_W-1:0]         in_row,
    input  wire logic [tcw_pkg::COL_FLD_W-1:0]         in_col,
    input  wire logic                                  cfg_we,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [tcw_pkg::COLOR_W-1:0]           cfg_data,
    input  wire logic                                  out_pop,
    output logic                                       out_valid,
    output logic [tcw_pkg::M_TDATA_W-1:0]              out_data
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int PAD_W = M_TDATA_W - CELL_W - ROW_FLD_W - COL_FLD_W - 1;

    logic [COLOR_W-1:0] fore_reg, back_reg;
    logic [RW-1:0]      row_reg, row_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [AW-1:0]      sweep_reg, sweep_next;
    logic               pend_vld_reg;
    logic [AW-1:0]      pend_addr_reg;
    logic               pend_zero_reg;
    logic               rd_zero_reg;
    logic               is_read_reg;
    logic               scrolled_reg, scrolled_next;
    logic               out_vld_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic               is_put, is_read, printable, line_end, at_last_row, in_range;
    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr, rd_addr, cursor_addr, item_addr;
    logic [CELL_W-1:0]  wr_data, rd_data, cell_out;
    logic               sweep_last, sweep_has_src;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // item decode
    always_comb begin
        is_put      = (in_kind == KIND_PUT);
        is_read     = (in_kind == KIND_READ);
        printable   = (in_char >= FIRST_PRINTABLE) && (in_char <= LAST_PRINTABLE);
        line_end    = (col_reg == CW'(COLUMNS - 1)) || (in_char == NEWLINE_CODE);
        at_last_row = (row_reg == RW'(ROWS - 1));
        in_range    = (int'(in_row) < ROWS) && (int'(in_col) < COLUMNS);
        cursor_addr = AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg);
        item_addr   = AW'(in_row) * AW'(COLUMNS) + AW'(in_col);
    end

    // cursor advance
    always_comb begin
        row_next      = row_reg;
        col_next      = col_reg;
        scrolled_next = scrolled_reg;
        if (cmd.accept) begin
            scrolled_next = 1'b0;
            if (is_put) begin
                if (line_end) begin
                    col_next = '0;
                    if (at_last_row) begin
                        scrolled_next = 1'b1;
                    end else begin
                        row_next = row_reg + RW'(1);
                    end
                end else begin
                    col_next = col_reg + CW'(1);
                end
            end
        end
    end

    // sweep: clear pass or scroll copy (read cell one row below, write it back via the pending-write register)
    always_comb begin
        sweep_last    = (sweep_reg == AW'(CELLS - 1));
        sweep_has_src = (sweep_reg < AW'(CELLS - COLUMNS));
        sweep_next    = sweep_reg;
        if (cmd.clear_step || cmd.scroll_step) begin
            sweep_next = sweep_last ? '0 : sweep_reg + AW'(1);
        end
    end

    // RAM port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cursor_addr;
        wr_data = {back_reg, fore_reg, in_char};
        priority if (pend_vld_reg) begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
            wr_data = pend_zero_reg ? '0 : rd_data;
        end else if (cmd.clear_step) begin
            wr_en   = 1'b1;
            wr_addr = sweep_reg;
            wr_data = '0;
        end else if (cmd.accept && is_put && printable) begin
            wr_en   = 1'b1;
        end

        rd_en   = 1'b0;
        rd_addr = item_addr;
        priority if (cmd.scroll_step) begin
            rd_en   = sweep_has_src;
            rd_addr = sweep_reg + AW'(COLUMNS);
        end else if (cmd.accept && is_read && in_range) begin
            rd_en   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fore_reg     <= '0;
            back_reg     <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            sweep_reg    <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_FORE_COLOR: fore_reg <= cfg_data;
                    CFG_BACK_COLOR: back_reg <= cfg_data;
                    default: ;
                endcase
            end
            row_reg      <= row_next;
            col_reg      <= col_next;
            sweep_reg    <= sweep_next;
            pend_vld_reg <= cmd.scroll_step;
            if (cmd.load_out) begin
                out_vld_reg <= 1'b1;
            end else if (out_pop) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scrolled_reg <= scrolled_next;
        if (cmd.scroll_step) begin
            pend_addr_reg <= sweep_reg;
            pend_zero_reg <= !sweep_has_src;
        end
        if (cmd.accept) begin
            is_read_reg <= is_read;
            rd_zero_reg <= !in_range;
        end
        if (cmd.load_out) begin
            out_data_reg <= {{PAD_W{1'b0}}, scrolled_reg, COL_FLD_W'(col_reg),
                             ROW_FLD_W'(row_reg), cell_out};
        end
    end

    assign cell_out = (is_read_reg && !rd_zero_reg) ? rd_data : '0;

    assign status.need_scroll = is_put && line_end && at_last_row;
    assign status.sweep_last  = sweep_last;
    assign status.out_free    = !out_vld_reg || out_pop;

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
// Controller state machine: clear pass, item accept, scroll sweep, result push.
// Depends on tcw_pkg.
`default_nettype none

module tcw_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    input  wire logic                 in_kind,
    output logic                      in_ready,
    input  wire tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t         cmd
);
    import tcw_pkg::*;

    tcw_state_t state_reg, state_next;

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        in_ready        = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    if (in_kind == KIND_PUT && status.need_scroll) begin
                        state_next = ST_SCROLL;
                    end else begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_SCROLL: begin
                cmd.scroll_step = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/text_console_writer.sv =====
// Text console writer: character terminal over a ROWS x COLUMNS store of 16-bit cells.
// Each item is accepted in the idle state, then its result is loaded into the output register in the push state.
// A put that runs past the last row adds a scroll sweep over all ROWS*COLUMNS cells,
// one cell move per cycle through the single write port of the screen RAM.
// After reset (aresetn low, synchronous) a clearing pass writes zero to all ROWS*COLUMNS
// cells, one per cycle, with s_tready low; cursor and colors reset to zero.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // char_code [7:0], cell_row [12:8], cell_col [19:13], zero [23:20]
    input  wire logic [tcw_pkg::S_TDATA_W-1:0]       s_tdata,
    // kind [0]
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // cell_data [15:0], cursor_row [20:16], cursor_col [27:21], scrolled [28], zero [31:29]
    output logic [tcw_pkg::M_TDATA_W-1:0]            m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tcw_pkg::COLOR_W-1:0]         cfg_data
);
    import tcw_pkg::*;

    tcw_cmd_t    cmd;
    tcw_status_t status;

    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_kind   (s_tuser),
        .in_char   (s_tdata[7:0]),
        .in_row    (s_tdata[12:8]),
        .in_col    (s_tdata[19:13]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_pop   (m_tvalid && m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for text_console_writer: a directed burst, then random
// put/read streams under several color settings. Depends on tcw_pkg.
module testbench;
    import tcw_pkg::*;

    localparam int COLS          = 80;
    localparam int ROWS          = 25;
    localparam int WATCHDOG_MAX  = 20000;
    localparam int LONG_HOLD     = 500;
    localparam int SETTLE_CYCLES = 8;
    // Indexes past the two color registers, written to check they are ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic                 kind;
        logic [CHAR_W-1:0]    char_code;
        logic [ROW_FLD_W-1:0] row;
        logic [COL_FLD_W-1:0] col;
    } console_op_t;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_data;
        logic [ROW_FLD_W-1:0] cursor_row;
        logic [COL_FLD_W-1:0] cursor_col;
        logic                 scrolled;
    } console_reply_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    wire                    s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    wire                    m_tvalid;
    logic                   m_tready = 1'b0;
    wire  [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    wire                    cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [COLOR_W-1:0]     cfg_data = '0;

    text_console_writer #(.COLUMNS(COLS), .ROWS(ROWS)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Shadow of the console: screen, cursor and colors.
    logic [CELL_W-1:0]  screen_model [ROWS][COLS];
    int                 cur_row, cur_col;
    logic [COLOR_W-1:0] fg_model, bg_model;

    console_op_t    console_ops[$];
    console_reply_t console_replies[$];

    int mismatches = 0;
    int ops_sent = 0, ops_accepted = 0, beats_out = 0;
    int reads_seen = 0, scrolls_seen = 0, reg_writes = 0;
    int holds_asked = 0, holds_served = 0, hold_left = 0;
    int idle_cycles = 0;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got 0x%0h, want 0x%0h (beat %0d, t=%0t)",
                 what, got, want, beats_out, $realtime);
        mismatches++;
    endtask

    function automatic console_reply_t apply_console_op(input console_op_t op);
        console_reply_t res;
        int r, c;
        res = '0;
        if (op.kind == KIND_READ) begin
            if (op.row < ROWS && op.col < COLS)
                res.cell_data = screen_model[op.row][op.col];
        end else begin
            if (op.char_code >= FIRST_PRINTABLE && op.char_code <= LAST_PRINTABLE)
                screen_model[cur_row][cur_col] = {bg_model, fg_model, op.char_code};
            cur_col++;
            if (cur_col >= COLS || op.char_code == NEWLINE_CODE) begin
                cur_row++;
                cur_col = 0;
                if (cur_row >= ROWS) begin
                    for (r = 1; r < ROWS; r++)
                        for (c = 0; c < COLS; c++)
                            screen_model[r-1][c] = screen_model[r][c];
                    for (c = 0; c < COLS; c++)
                        screen_model[ROWS-1][c] = '0;
                    cur_row = ROWS - 1;
                    res.scrolled = 1'b1;
                end
            end
        end
        res.cursor_row = ROW_FLD_W'(cur_row);
        res.cursor_col = COL_FLD_W'(cur_col);
        return res;
    endfunction

    function automatic console_op_t random_op(input int read_pct, input int nl_pct);
        console_op_t op;
        int pick;
        op.char_code = CHAR_W'($urandom);
        op.row = ROW_FLD_W'($urandom);
        op.col = COL_FLD_W'($urandom);
        if ($urandom_range(0, 99) < read_pct) begin
            op.kind = KIND_READ;
            // mostly on-screen, sometimes anywhere the fields reach
            if ($urandom_range(0, 9) != 0) begin
                op.row = ROW_FLD_W'($urandom_range(0, ROWS - 1));
                op.col = COL_FLD_W'($urandom_range(0, COLS - 1));
            end
        end else begin
            op.kind = KIND_PUT;
            pick = $urandom_range(0, 99);
            if (pick < nl_pct)
                op.char_code = NEWLINE_CODE;
            else if (pick < 80)
                op.char_code = CHAR_W'($urandom_range(FIRST_PRINTABLE, LAST_PRINTABLE));
        end
        return op;
    endfunction

    task automatic queue_put(input logic [CHAR_W-1:0] ch);
        console_op_t op;
        op = '0;
        op.kind = KIND_PUT;
        op.char_code = ch;
        console_ops.push_back(op);
    endtask

    task automatic queue_read(input logic [ROW_FLD_W-1:0] r, input logic [COL_FLD_W-1:0] c);
        console_op_t op;
        op = '0;
        op.kind = KIND_READ;
        op.row = r;
        op.col = c;
        console_ops.push_back(op);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (console_ops.size() != 0 || ops_sent != ops_accepted ||
               console_replies.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        console_op_t op;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            burst_left = 4;
            gap_left = 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (console_ops.size() != 0) begin
                op = console_ops.pop_front();
                ops_sent++;
                s_tuser  <= op.kind;
                s_tdata  <= {4'b0, op.col, op.row, op.char_code};
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: rotating stall pattern that rx_tick reshuffles, plus long holds.
    logic [15:0] rx_pattern = 16'hA5C3;
    logic        rx_open = 1'b0;
    int          rx_tick = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            rx_tick++;
            if (rx_tick % 48 == 0) begin
                rx_pattern = 16'($urandom);
                rx_open    = ($urandom_range(0, 3) == 0);
            end
            rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
            m_tready <= rx_open | rx_pattern[0];
        end
    end

    // Monitor: checks result beats, predicts on accepted input beats, tracks config.
    always @(posedge aclk) begin
        console_reply_t want;
        console_op_t    op;
        int r, c;
        if (!aresetn) begin
            for (r = 0; r < ROWS; r++)
                for (c = 0; c < COLS; c++)
                    screen_model[r][c] = '0;
            cur_row  = 0;
            cur_col  = 0;
            fg_model = '0;
            bg_model = '0;
        end else begin
            idle_cycles++;
            if (m_tvalid && m_tready) begin
                idle_cycles = 0;
                beats_out++;
                if (console_replies.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding", m_tdata, 0);
                end else begin
                    want = console_replies.pop_front();
                    if (m_tdata[15:0] !== want.cell_data)
                        report_mismatch("cell_data", m_tdata[15:0], want.cell_data);
                    if (m_tdata[20:16] !== want.cursor_row)
                        report_mismatch("cursor_row", m_tdata[20:16], want.cursor_row);
                    if (m_tdata[27:21] !== want.cursor_col)
                        report_mismatch("cursor_col", m_tdata[27:21], want.cursor_col);
                    if (m_tdata[28] !== want.scrolled)
                        report_mismatch("scrolled", m_tdata[28], want.scrolled);
                end
            end
            if (s_tvalid && s_tready) begin
                idle_cycles = 0;
                op.kind      = s_tuser;
                op.char_code = s_tdata[7:0];
                op.row       = s_tdata[12:8];
                op.col       = s_tdata[19:13];
                want = apply_console_op(op);
                console_replies.push_back(want);
                ops_accepted++;
                if (op.kind == KIND_READ)
                    reads_seen++;
                if (want.scrolled)
                    scrolls_seen++;
            end
            if (cfg_valid && cfg_ready) begin
                idle_cycles = 0;
                reg_writes++;
                case (cfg_index)
                    CFG_FORE_COLOR: fg_model = cfg_data;
                    CFG_BACK_COLOR: bg_model = cfg_data;
                    default: ;
                endcase
            end
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("Timeout: no beat for %0d cycles", WATCHDOG_MAX);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int ph, i, n, rd_pct, nl_pct;
        logic [COLOR_W-1:0] fg, bg;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        write_reg(CFG_FORE_COLOR, 4'hF);
        write_reg(CFG_BACK_COLOR, 4'h0);
        write_reg(CFG_SPARE_LO, 4'hA);
        write_reg(CFG_SPARE_HI, 4'h5);

        // directed: cleared store, printable edges, non-printables, newline,
        // read-back, off-screen reads
        queue_read(5'd0, 7'd0);
        queue_read(ROW_FLD_W'(ROWS - 1), COL_FLD_W'(COLS - 1));
        queue_put(8'd65);
        queue_put(FIRST_PRINTABLE);
        queue_put(LAST_PRINTABLE);
        queue_put(8'd31);
        queue_put(8'd128);
        queue_put(8'd255);
        queue_put(8'd0);
        queue_put(NEWLINE_CODE);
        queue_put(8'd126);
        for (i = 0; i < 5; i++)
            queue_read(5'd0, COL_FLD_W'(i));
        queue_read(5'd0, 7'd7);
        queue_read(5'd1, 7'd0);
        queue_read(ROW_FLD_W'(ROWS), 7'd0);
        queue_read(5'd31, 7'd127);
        queue_read(5'd0, COL_FLD_W'(COLS));
        queue_read(ROW_FLD_W'(ROWS - 1), 7'd127);
        queue_read(5'd16, 7'd64);

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin fg = 4'h0; bg = 4'hF; n = 100; rd_pct = 25; nl_pct = 20; end
                1: begin fg = 4'hF; bg = 4'hF; n = 100; rd_pct = 25; nl_pct = 20; end
                2: begin
                    fg = COLOR_W'($urandom); bg = COLOR_W'($urandom);
                    n = 200; rd_pct = 10; nl_pct = 1;
                end
                3: begin fg = 4'h0; bg = 4'h0; n = 100; rd_pct = 30; nl_pct = 25; end
                default: begin
                    fg = COLOR_W'($urandom); bg = COLOR_W'($urandom);
                    n = 100; rd_pct = 25; nl_pct = 15;
                end
            endcase
            wait_idle();
            write_reg(CFG_FORE_COLOR, fg);
            write_reg(CFG_BACK_COLOR, bg);
            // back-pressure the output long enough for the input to stall
            if (ph == 1)
                holds_asked++;
            for (i = 0; i < n; i++)
                console_ops.push_back(random_op(rd_pct, nl_pct));
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (console_replies.size() != 0)
            report_mismatch("results never delivered", console_replies.size(), 0);

        $display("Covered %0d beats (%0d reads, %0d puts), %0d scrolls, %0d register writes",
                 ops_accepted, reads_seen, ops_accepted - reads_seen, scrolls_seen, reg_writes);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_datapath.sv
sv/tcw_ctrl.sv
sv/text_console_writer.sv
tb/testbench.sv
